### rtl/lqpi_pkg.sv
// Shared types, constants and arithmetic helpers for the luma quarter-sample core.
package lqpi_pkg;

    localparam int SAMPLE_W    = 14;
    localparam int VW          = 28;
    localparam int HW          = 22;
    localparam int TAPS        = 6;
    localparam int BANKS       = 8;
    localparam int BANK_BITS   = 3;
    localparam int MAX_PIC_WIDTH_DEF  = 256;
    localparam int MAX_PIC_HEIGHT_DEF = 256;

    localparam logic OP_WRITE  = 1'b0;
    localparam logic OP_INTERP = 1'b1;

    localparam logic [1:0] REG_WIDTH  = 2'd0;
    localparam logic [1:0] REG_HEIGHT = 2'd1;
    localparam logic [1:0] REG_DEPTH  = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_FETCH,
        ST_FILTER,
        ST_SELECT
    } lqpi_state_t;

    typedef struct packed {
        logic       cap_en;
        logic [2:0] cap_row;
        logic       flt_en;
    } lqpi_ctrl_t;

    // Widen an unsigned sample to the signed filter width
    function automatic logic signed [VW-1:0] ext_s(input logic [SAMPLE_W-1:0] x);
        ext_s = $signed({{(VW-SAMPLE_W){1'b0}}, x});
    endfunction

    // Six-tap filter (1,-5,20,20,-5,1)
    function automatic logic signed [VW-1:0] tap6(
        input logic signed [VW-1:0] a,
        input logic signed [VW-1:0] b,
        input logic signed [VW-1:0] c,
        input logic signed [VW-1:0] d,
        input logic signed [VW-1:0] e,
        input logic signed [VW-1:0] f
    );
        tap6 = VW'(a - 5 * b + 20 * c + 20 * d - 5 * e + f);
    endfunction

    // Add rounding, shift down and clip to 0 .. maxv
    function automatic logic [SAMPLE_W-1:0] round_clip(
        input logic signed [VW-1:0] v,
        input logic signed [VW-1:0] rnd,
        input logic [3:0]           sh,
        input logic [SAMPLE_W-1:0]  maxv
    );
        logic signed [VW-1:0] t;
        logic [VW-1:0]        u;
        t = v + rnd;
        u = $unsigned(t) >> sh;
        if (t < 0)
            round_clip = '0;
        else if (u > {{(VW-SAMPLE_W){1'b0}}, maxv})
            round_clip = maxv;
        else
            round_clip = u[SAMPLE_W-1:0];
    endfunction

    // Average of two samples, rounding up
    function automatic logic [SAMPLE_W-1:0] avg2(
        input logic [SAMPLE_W-1:0] a,
        input logic [SAMPLE_W-1:0] b
    );
        logic [SAMPLE_W:0] s;
        s = {1'b0, a} + {1'b0, b} + {{SAMPLE_W{1'b0}}, 1'b1};
        avg2 = s[SAMPLE_W:1];
    endfunction

endpackage

### rtl/lqpi_mem.sv
// Eight-bank reference picture memory with one write port and a six-column row read.
module lqpi_mem
    import lqpi_pkg::*;
#(
    parameter int XW = 8,
    parameter int YW = 8
)
(
    input  logic                clk,
    input  logic                wr_en,
    input  logic [XW-1:0]       wr_x,
    input  logic [YW-1:0]       wr_y,
    input  logic [SAMPLE_W-1:0] wr_data,
    input  logic                rd_en,
    input  logic [YW-1:0]       rd_y,
    input  logic [XW-1:0]       rd_x [TAPS],
    output logic [SAMPLE_W-1:0] rd_data [TAPS]
);

    localparam int CW    = XW - BANK_BITS;
    localparam int AW    = YW + CW;
    localparam int DEPTH = 1 << AW;

    logic [CW-1:0]        bank_col [BANKS];
    logic [SAMPLE_W-1:0]  bank_q   [BANKS];
    logic [BANK_BITS-1:0] sel_reg  [TAPS];

    // Route each column of the window to the bank that holds it
    always_comb
    begin
        for (int b = 0; b < BANKS; b++)
        begin
            bank_col[b] = rd_x[0][XW-1:BANK_BITS];
            for (int k = 0; k < TAPS; k++)
            begin
                if (rd_x[k][BANK_BITS-1:0] == BANK_BITS'(b))
                    bank_col[b] = rd_x[k][XW-1:BANK_BITS];
            end
        end
    end

    for (genvar gb = 0; gb < BANKS; gb++)
    begin : g_bank
        logic [SAMPLE_W-1:0] mem [DEPTH];
        logic [SAMPLE_W-1:0] q_reg;

        // Write and read the bank
        always_ff @(posedge clk)
        begin
            if (wr_en && wr_x[BANK_BITS-1:0] == BANK_BITS'(gb))
                mem[{wr_y, wr_x[XW-1:BANK_BITS]}] <= wr_data;
            if (rd_en)
                q_reg <= mem[{rd_y, bank_col[gb]}];
        end

        assign bank_q[gb] = q_reg;
    end

    // Hold bank selects alongside the read
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            for (int k = 0; k < TAPS; k++)
                sel_reg[k] <= rd_x[k][BANK_BITS-1:0];
        end
    end

    always_comb
    begin
        for (int k = 0; k < TAPS; k++)
            rd_data[k] = bank_q[sel_reg[k]];
    end

endmodule

### rtl/lqpi_filter.sv
// Row capture, six-tap half-sample filters and quarter-sample selection.
module lqpi_filter
    import lqpi_pkg::*;
(
    input  logic                clk,
    input  lqpi_ctrl_t          ctrl,
    input  logic [SAMPLE_W-1:0] taps [TAPS],
    input  logic [1:0]          x_frac,
    input  logic [1:0]          y_frac,
    input  logic [SAMPLE_W-1:0] max_val,
    output logic [SAMPLE_W-1:0] predicted
);

    logic signed [HW-1:0] hs_reg [TAPS];
    logic [SAMPLE_W-1:0]  c0_reg [TAPS];
    logic [SAMPLE_W-1:0]  c1_reg [TAPS];
    logic signed [VW-1:0] j_raw_reg;
    logic signed [VW-1:0] h_raw_reg;
    logic signed [VW-1:0] m_raw_reg;
    logic signed [VW-1:0] row_sum;
    logic signed [VW-1:0] hs_ext [TAPS];
    logic [SAMPLE_W-1:0]  g_s, h_int, m_int, b_s, s_s, h_s, m_s, j_s;

    // Horizontal sum of the incoming row
    assign row_sum = tap6(ext_s(taps[0]), ext_s(taps[1]), ext_s(taps[2]),
                          ext_s(taps[3]), ext_s(taps[4]), ext_s(taps[5]));

    always_comb
    begin
        for (int r = 0; r < TAPS; r++)
            hs_ext[r] = VW'(hs_reg[r]);
    end

    // Capture a row, then run the vertical filters
    always_ff @(posedge clk)
    begin
        if (ctrl.cap_en)
        begin
            hs_reg[ctrl.cap_row] <= HW'(row_sum);
            c0_reg[ctrl.cap_row] <= taps[2];
            c1_reg[ctrl.cap_row] <= taps[3];
        end
        if (ctrl.flt_en)
        begin
            j_raw_reg <= tap6(hs_ext[0], hs_ext[1], hs_ext[2],
                              hs_ext[3], hs_ext[4], hs_ext[5]);
            h_raw_reg <= tap6(ext_s(c0_reg[0]), ext_s(c0_reg[1]), ext_s(c0_reg[2]),
                              ext_s(c0_reg[3]), ext_s(c0_reg[4]), ext_s(c0_reg[5]));
            m_raw_reg <= tap6(ext_s(c1_reg[0]), ext_s(c1_reg[1]), ext_s(c1_reg[2]),
                              ext_s(c1_reg[3]), ext_s(c1_reg[4]), ext_s(c1_reg[5]));
        end
    end

    // Round and clip the half samples
    always_comb
    begin
        g_s   = c0_reg[2];
        h_int = c1_reg[2];
        m_int = c0_reg[3];
        b_s   = round_clip(hs_ext[2], VW'(16), 4'd5, max_val);
        s_s   = round_clip(hs_ext[3], VW'(16), 4'd5, max_val);
        h_s   = round_clip(h_raw_reg, VW'(16), 4'd5, max_val);
        m_s   = round_clip(m_raw_reg, VW'(16), 4'd5, max_val);
        j_s   = round_clip(j_raw_reg, VW'(512), 4'd10, max_val);
    end

    // Pick the sample for the fraction
    always_comb
    begin
        case ({x_frac, y_frac})
            4'd0:    predicted = g_s;
            4'd1:    predicted = avg2(g_s, h_s);
            4'd2:    predicted = h_s;
            4'd3:    predicted = avg2(m_int, h_s);
            4'd4:    predicted = avg2(g_s, b_s);
            4'd5:    predicted = avg2(b_s, h_s);
            4'd6:    predicted = avg2(h_s, j_s);
            4'd7:    predicted = avg2(h_s, s_s);
            4'd8:    predicted = b_s;
            4'd9:    predicted = avg2(b_s, j_s);
            4'd10:   predicted = j_s;
            4'd11:   predicted = avg2(j_s, s_s);
            4'd12:   predicted = avg2(b_s, h_int);
            4'd13:   predicted = avg2(b_s, m_s);
            4'd14:   predicted = avg2(j_s, m_s);
            default: predicted = avg2(s_s, m_s);
        endcase
    end

endmodule

### rtl/luma_quarter_pel_interpolation_core.sv
// Top level of the luma quarter-sample interpolation core.
// A write request leaves the core idle, so it is ready again for the next request.
// An interpolate request occupies the core before the next request is taken: the
// fetch state reads the 6x6 neighborhood from the eight-bank picture memory, one
// row of six clamped columns per cycle through the registered bank reads, then the
// filter state runs the vertical filters and the select state rounds, selects and
// loads the result register (waiting while that register is still held by a stall).
// Samples read before they were written return unspecified values.
module luma_quarter_pel_interpolation_core
    import lqpi_pkg::*;
#(
    parameter int MAX_PIC_WIDTH  = MAX_PIC_WIDTH_DEF,
    parameter int MAX_PIC_HEIGHT = MAX_PIC_HEIGHT_DEF
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    output logic                item_ready,
    input  logic                operation,
    input  logic signed [10:0]  x_pos,
    input  logic signed [10:0]  y_pos,
    input  logic [1:0]          x_frac,
    input  logic [1:0]          y_frac,
    input  logic [SAMPLE_W-1:0] write_sample,
    output logic                result_valid,
    input  logic                result_ready,
    output logic [SAMPLE_W-1:0] predicted_sample,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam int XW = $clog2(MAX_PIC_WIDTH);
    localparam int YW = $clog2(MAX_PIC_HEIGHT);
    localparam int SW = ((XW > YW ? XW : YW) > 11 ? (XW > YW ? XW : YW) : 11) + 2;

    lqpi_state_t state_reg, state_next;
    logic [2:0]  cnt_reg, cnt_next;
    logic [4:0]  width_mb_reg, height_mb_reg;
    logic [3:0]  depth_reg;
    logic signed [10:0]  org_x_reg, org_y_reg;
    logic [1:0]          fx_reg, fy_reg;
    logic [XW-1:0]       xmax_reg, xmax_next;
    logic [YW-1:0]       ymax_reg, ymax_next;
    logic [SAMPLE_W-1:0] maxv_reg, maxv_next;
    logic                res_valid_reg;
    logic [SAMPLE_W-1:0] res_reg;

    logic                item_acc, cfg_wr, load_out, wr_en, rd_en, in_store;
    logic [XW-1:0]       wr_x, rd_x [TAPS];
    logic [YW-1:0]       wr_y, rd_y;
    logic [SAMPLE_W-1:0] rd_data [TAPS];
    logic [SAMPLE_W-1:0] predicted;
    lqpi_ctrl_t          ctrl;
    logic signed [SW-1:0] xe, ye, rv, ry;
    int                  wt, ht, dt;

    assign item_acc = item_valid && item_ready;
    assign cfg_wr   = psel && penable && pwrite && pready;
    assign pready   = 1'b1;

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_mb_reg  <= 5'd16;
            height_mb_reg <= 5'd16;
            depth_reg     <= 4'd8;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_WIDTH:  width_mb_reg  <= pwdata[4:0];
                REG_HEIGHT: height_mb_reg <= pwdata[4:0];
                REG_DEPTH:  depth_reg     <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[3:2])
            REG_WIDTH:  prdata = {27'd0, width_mb_reg};
            REG_HEIGHT: prdata = {27'd0, height_mb_reg};
            REG_DEPTH:  prdata = {28'd0, depth_reg};
            default:    prdata = '0;
        endcase
    end

    // Saturate picture size and bit depth into clamp limits
    always_comb
    begin
        wt = int'(width_mb_reg);
        ht = int'(height_mb_reg);
        dt = int'(depth_reg);
        if (wt < 1) wt = 1;
        if (wt > MAX_PIC_WIDTH / 16) wt = MAX_PIC_WIDTH / 16;
        if (ht < 1) ht = 1;
        if (ht > MAX_PIC_HEIGHT / 16) ht = MAX_PIC_HEIGHT / 16;
        if (dt < 8) dt = 8;
        if (dt > 14) dt = 14;
        xmax_next = XW'(wt * 16 - 1);
        ymax_next = YW'(ht * 16 - 1);
        maxv_next = SAMPLE_W'((1 << dt) - 1);
    end

    // Latch the request
    always_ff @(posedge clk)
    begin
        if (item_acc && operation == OP_INTERP)
        begin
            org_x_reg <= x_pos;
            org_y_reg <= y_pos;
            fx_reg    <= x_frac;
            fy_reg    <= y_frac;
            xmax_reg  <= xmax_next;
            ymax_reg  <= ymax_next;
            maxv_reg  <= maxv_next;
        end
    end

    // Drop writes outside storage
    always_comb
    begin
        xe       = SW'(x_pos);
        ye       = SW'(y_pos);
        in_store = (int'(x_pos) >= 0) && (int'(x_pos) < MAX_PIC_WIDTH)
                && (int'(y_pos) >= 0) && (int'(y_pos) < MAX_PIC_HEIGHT);
        wr_x     = xe[XW-1:0];
        wr_y     = ye[YW-1:0];
        wr_en    = item_acc && operation == OP_WRITE && in_store;
    end

    // Clamp the window columns and the fetched row to the picture
    always_comb
    begin
        for (int k = 0; k < TAPS; k++)
        begin
            rv = SW'(org_x_reg) + SW'(k) - SW'(2);
            if (rv < 0)
                rd_x[k] = '0;
            else if (rv > $signed({{(SW-XW){1'b0}}, xmax_reg}))
                rd_x[k] = xmax_reg;
            else
                rd_x[k] = rv[XW-1:0];
        end
        ry = SW'(org_y_reg) + SW'(cnt_reg) - SW'(2);
        if (ry < 0)
            rd_y = '0;
        else if (ry > $signed({{(SW-YW){1'b0}}, ymax_reg}))
            rd_y = ymax_reg;
        else
            rd_y = ry[YW-1:0];
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = 3'd0;
        unique case (state_reg)
            ST_IDLE:
                if (item_acc && operation == OP_INTERP)
                    state_next = ST_FETCH;
            ST_FETCH:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'(TAPS))
                begin
                    state_next = ST_FILTER;
                    cnt_next   = 3'd0;
                end
            end
            ST_FILTER:
                state_next = ST_SELECT;
            ST_SELECT:
                if (!res_valid_reg || result_ready)
                    state_next = ST_IDLE;
            default:
                state_next = ST_IDLE;
        endcase
    end

    // State outputs
    always_comb
    begin
        item_ready   = 1'b0;
        rd_en        = 1'b0;
        ctrl.cap_en  = 1'b0;
        ctrl.cap_row = cnt_reg - 3'd1;
        ctrl.flt_en  = 1'b0;
        load_out     = 1'b0;
        unique case (state_reg)
            ST_IDLE:
                item_ready = 1'b1;
            ST_FETCH:
            begin
                rd_en       = cnt_reg < 3'(TAPS);
                ctrl.cap_en = cnt_reg != 3'd0;
            end
            ST_FILTER:
                ctrl.flt_en = 1'b1;
            ST_SELECT:
                load_out = !res_valid_reg || result_ready;
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= 3'd0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
            if (load_out)
                res_valid_reg <= 1'b1;
            else if (result_ready)
                res_valid_reg <= 1'b0;
        end
    end

    // Output register
    always_ff @(posedge clk)
    begin
        if (load_out)
            res_reg <= predicted;
    end

    assign result_valid     = res_valid_reg;
    assign predicted_sample = res_reg;

    lqpi_mem #(
        .XW (XW),
        .YW (YW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_x    (wr_x),
        .wr_y    (wr_y),
        .wr_data (write_sample),
        .rd_en   (rd_en),
        .rd_y    (rd_y),
        .rd_x    (rd_x),
        .rd_data (rd_data)
    );

    lqpi_filter u_filter (
        .clk       (clk),
        .ctrl      (ctrl),
        .taps      (rd_data),
        .x_frac    (fx_reg),
        .y_frac    (fy_reg),
        .max_val   (maxv_reg),
        .predicted (predicted)
    );

endmodule

### rtl/lqpi_checker.sv
// Port-level assertions for the luma quarter-sample core, bound to the top level.
module lqpi_checker
    import lqpi_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                item_valid,
    input logic                item_ready,
    input logic                operation,
    input logic                result_valid,
    input logic                result_ready,
    input logic [SAMPLE_W-1:0] predicted_sample
);

    // Hold a stalled result
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(predicted_sample))
        else $error("stalled result changed");

    // Interpolate request blocks the input
    a_interp_busy: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && operation == OP_INTERP |=> !item_ready)
        else $error("input ready during interpolation");

    // Write request keeps the input open
    a_write_free: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready && operation == OP_WRITE |=> item_ready)
        else $error("write stalled the input");

endmodule

bind luma_quarter_pel_interpolation_core lqpi_checker u_lqpi_checker (.*);

### tb/sv/luma_quarter_pel_interpolation_core_checker.sv
// Checker for the luma quarter-sample core: watches requests and results, predicts, compares.
module luma_quarter_pel_interpolation_core_checker
    import lqpi_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                item_valid,
    input  logic                item_ready,
    input  logic                operation,
    input  logic signed [10:0]  x_pos,
    input  logic signed [10:0]  y_pos,
    input  logic [1:0]          x_frac,
    input  logic [1:0]          y_frac,
    input  logic [SAMPLE_W-1:0] write_sample,
    input  logic                result_valid,
    input  logic                result_ready,
    input  logic [SAMPLE_W-1:0] predicted_sample,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [3:0]          paddr,
    input  logic [31:0]         pwdata,
    input  logic                pready,
    output int                  error_count,
    output int                  samples_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STORE_W = 256;
    localparam int STORE_H = 256;

    logic [SAMPLE_W-1:0] ref_picture [0:STORE_W*STORE_H-1];
    logic [SAMPLE_W-1:0] sample_queue [$];
    logic [4:0]          width_mb;
    logic [4:0]          height_mb;
    logic [3:0]          bit_depth;
    int                  pic_w;
    int                  pic_h;
    int                  max_v;
    int                  org_x;
    int                  org_y;

    function automatic int clampi(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Fetch a neighbor sample, clamped to the picture edge
    function automatic int pel(input int dx, input int dy);
        int cx;
        int cy;
        cx = clampi(org_x + dx, 0, pic_w - 1);
        cy = clampi(org_y + dy, 0, pic_h - 1);
        return int'(ref_picture[cy*STORE_W + cx]);
    endfunction

    function automatic int six_tap(input int a, input int b, input int c,
                                   input int d, input int e, input int f);
        return a - 5*b + 20*c + 20*d - 5*e + f;
    endfunction

    function automatic int round_sat(input int v, input int add, input int sh);
        int t;
        t = v + add;
        if (t < 0)
            return 0;
        t = t >>> sh;
        return t > max_v ? max_v : t;
    endfunction

    function automatic int row_sum(input int dy);
        return six_tap(pel(-2, dy), pel(-1, dy), pel(0, dy), pel(1, dy), pel(2, dy), pel(3, dy));
    endfunction

    function automatic int col_half(input int dx);
        return round_sat(six_tap(pel(dx, -2), pel(dx, -1), pel(dx, 0), pel(dx, 1),
                                 pel(dx, 2), pel(dx, 3)), 16, 5);
    endfunction

    function automatic int mean2(input int a, input int b);
        return (a + b + 1) >> 1;
    endfunction

    // Quarter-sample prediction at (org_x, org_y) + (fx, fy)/4
    function automatic int quarter_pel(input logic [1:0] fx, input logic [1:0] fy);
        int g;
        int hh;
        int mm;
        int b;
        int s;
        int h;
        int m;
        int j;
        g  = pel(0, 0);
        hh = pel(1, 0);
        mm = pel(0, 1);
        b  = round_sat(row_sum(0), 16, 5);
        s  = round_sat(row_sum(1), 16, 5);
        h  = col_half(0);
        m  = col_half(1);
        j  = round_sat(six_tap(row_sum(-2), row_sum(-1), row_sum(0), row_sum(1),
                               row_sum(2), row_sum(3)), 512, 10);
        case ({fx, fy})
            4'd0:    return g;
            4'd1:    return mean2(g, h);
            4'd2:    return h;
            4'd3:    return mean2(mm, h);
            4'd4:    return mean2(g, b);
            4'd5:    return mean2(b, h);
            4'd6:    return mean2(h, j);
            4'd7:    return mean2(h, s);
            4'd8:    return b;
            4'd9:    return mean2(b, j);
            4'd10:   return j;
            4'd11:   return mean2(j, s);
            4'd12:   return mean2(b, hh);
            4'd13:   return mean2(b, m);
            4'd14:   return mean2(j, m);
            default: return mean2(s, m);
        endcase
    endfunction

    // Track config writes, requests and results
    always @(posedge clk or negedge rst_n)
    begin
        int            xi;
        int            yi;
        logic [SAMPLE_W-1:0] want;
        if (!rst_n)
        begin
            width_mb        <= 5'd16;
            height_mb       <= 5'd16;
            bit_depth       <= 4'd8;
            error_count     <= 0;
            samples_pending <= 0;
            sample_queue.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_WIDTH:  width_mb  <= pwdata[4:0];
                    REG_HEIGHT: height_mb <= pwdata[4:0];
                    REG_DEPTH:  bit_depth <= pwdata[3:0];
                    default: ;
                endcase
            end
            if (item_valid && item_ready)
            begin
                xi = int'(x_pos);
                yi = int'(y_pos);
                if (operation == OP_WRITE)
                begin
                    if (xi >= 0 && xi < STORE_W && yi >= 0 && yi < STORE_H)
                        ref_picture[yi*STORE_W + xi] = write_sample;
                end
                else
                begin
                    pic_w = 16 * clampi(int'(width_mb), 1, STORE_W / 16);
                    pic_h = 16 * clampi(int'(height_mb), 1, STORE_H / 16);
                    max_v = (1 << clampi(int'(bit_depth), 8, 14)) - 1;
                    org_x = xi;
                    org_y = yi;
                    sample_queue.push_back(SAMPLE_W'(quarter_pel(x_frac, y_frac)));
                end
            end
            if (result_valid && result_ready)
            begin
                if (sample_queue.size() == 0)
                begin
                    if (error_count < 10)
                        $display("unexpected result: predicted_sample=%0d", predicted_sample);
                    error_count <= error_count + 1;
                end
                else
                begin
                    want = sample_queue.pop_front();
                    if (want !== predicted_sample)
                    begin
                        if (error_count < 10)
                            $display("mismatch: predicted_sample expected %0d got %0d",
                                     want, predicted_sample);
                        error_count <= error_count + 1;
                    end
                end
            end
            samples_pending <= sample_queue.size();
        end
    end

endmodule

### tb/sv/luma_quarter_pel_interpolation_core_test.sv
// Stimulus and verdict for the luma quarter-sample interpolation core.
module luma_quarter_pel_interpolation_core_test;
    import lqpi_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int DRAIN_WAIT  = 16;

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_ready;
    logic                operation;
    logic signed [10:0]  x_pos;
    logic signed [10:0]  y_pos;
    logic [1:0]          x_frac;
    logic [1:0]          y_frac;
    logic [SAMPLE_W-1:0] write_sample;
    logic                result_valid;
    logic                result_ready;
    logic [SAMPLE_W-1:0] predicted_sample;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [3:0]          paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;
    int                  error_count;
    int                  samples_pending;

    int                  send_idle_pct;
    int                  recv_stall_pct;
    int                  holdoff_asked;
    int                  holdoff_done;
    int                  cycles;
    int                  pic_w;
    int                  pic_h;
    bit                  filled [0:65535];

    luma_quarter_pel_interpolation_core dut (.*);

    luma_quarter_pel_interpolation_core_checker checker_i (.*);

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    // Abort on a hung run
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("luma_quarter_pel_interpolation_core_test: errors");
            $finish;
        end
    end

    // Drive result_ready: random stalls, or a long hold-off when asked
    initial
    begin
        result_ready = 1'b0;
        holdoff_done = 0;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (holdoff_asked != holdoff_done)
            begin
                result_ready <= 1'b0;
                holdoff_done = holdoff_done + 1;
                repeat (300) @(posedge clk);
            end
            result_ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    function automatic int clampi(input int v, input int lo, input int hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_request(input logic op, input int x, input int y,
                                input int fx, input int fy, input int s);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct)
            gap++;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid   <= 1'b1;
        operation    <= op;
        x_pos        <= 11'(x);
        y_pos        <= 11'(y);
        x_frac       <= 2'(fx);
        y_frac       <= 2'(fy);
        write_sample <= SAMPLE_W'(s);
        do
            @(posedge clk);
        while (!item_ready);
        if (op == OP_WRITE && x >= 0 && x < 256 && y >= 0 && y < 256)
            filled[y*256 + x] = 1'b1;
    endtask

    function automatic int pick_sample();
        case ($urandom_range(5))
            0:       return 0;
            1:       return (1 << SAMPLE_W) - 1;
            2:       return $urandom_range(255);
            default: return $urandom_range((1 << SAMPLE_W) - 1);
        endcase
    endfunction

    // Write any unwritten sample of the 6x6 window, then request
    task automatic interpolate(input int x, input int y, input int fx, input int fy);
        int cx;
        int cy;
        for (int dy = -2; dy <= 3; dy++)
            for (int dx = -2; dx <= 3; dx++)
            begin
                cx = clampi(x + dx, 0, pic_w - 1);
                cy = clampi(y + dy, 0, pic_h - 1);
                if (!filled[cy*256 + cx])
                    send_request(OP_WRITE, cx, cy, 0, 0, pick_sample());
            end
        send_request(OP_INTERP, x, y, fx, fy, $urandom_range((1 << SAMPLE_W) - 1));
    endtask

    // Drop valid and wait until every result is back
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (samples_pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic reg_write(input logic [1:0] idx, input int value);
        @(posedge clk);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= 32'(value);
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic configure(input int w, input int h, input int d);
        reg_write(REG_WIDTH, w);
        reg_write(REG_HEIGHT, h);
        reg_write(REG_DEPTH, d);
        pic_w = 16 * clampi(w & 31, 1, 16);
        pic_h = 16 * clampi(h & 31, 1, 16);
    endtask

    // Mostly near the picture edges, so that windows reuse written samples
    function automatic int pick_coord(input int extent);
        case ($urandom_range(9))
            0:       return -1024 + $urandom_range(2047);
            1:       return $urandom_range(1) ? -1024 : 1023;
            default: return $urandom_range(1) ? int'($urandom_range(5)) - 3
                                              : extent - 3 + int'($urandom_range(5));
        endcase
    endfunction

    initial
    begin
        int cfg_w [6] = '{1, 0, 16, 31, 3, 5};
        int cfg_h [6] = '{1, 0, 16, 31, 2, 7};
        int cfg_d [6] = '{8, 15, 14, 0, 10, 12};
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        operation      = OP_WRITE;
        x_pos          = '0;
        y_pos          = '0;
        x_frac         = '0;
        y_frac         = '0;
        write_sample   = '0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        cycles         = 0;
        holdoff_asked  = 0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        pic_w          = 256;
        pic_h          = 256;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: writes outside storage, sample extremes, every fraction at one corner
        send_request(OP_WRITE, -1, 5, 0, 0, 123);
        send_request(OP_WRITE, 5, 256, 0, 0, 77);
        send_request(OP_WRITE, 1023, -1024, 0, 0, 1);
        send_request(OP_WRITE, 0, 0, 0, 0, (1 << SAMPLE_W) - 1);
        send_request(OP_WRITE, 1, 0, 0, 0, 0);
        for (int f = 0; f < 16; f++)
            interpolate(-1024, -1024, f >> 2, f & 3);
        interpolate(1023, 1023, 3, 3);
        interpolate(1023, 1023, 2, 2);
        interpolate(254, 0, 1, 2);
        drain();

        for (int ph = 0; ph < 6; ph++)
        begin
            case (ph / 2)
                0:       begin send_idle_pct = 21; recv_stall_pct = 76; end
                1:       begin send_idle_pct = 76; recv_stall_pct = 21; end
                default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            endcase
            configure(cfg_w[ph], cfg_h[ph], cfg_d[ph]);
            if (ph == 4)
            begin
                // Hold results back so the core backs up its input
                holdoff_asked = holdoff_asked + 1;
                for (int k = 0; k < 20; k++)
                    interpolate(pick_coord(pic_w), pick_coord(pic_h),
                                $urandom_range(3), $urandom_range(3));
            end
            for (int k = 0; k < 45; k++)
            begin
                if (k == 22)
                    drain();
                if ($urandom_range(9) < 3)
                begin
                    if ($urandom_range(3) == 0)
                        send_request(OP_WRITE, -1024 + $urandom_range(2047),
                                     -1024 + $urandom_range(2047), 0, 0, pick_sample());
                    else
                        send_request(OP_WRITE, $urandom_range(pic_w - 1),
                                     $urandom_range(pic_h - 1), $urandom_range(3),
                                     $urandom_range(3), pick_sample());
                end
                else
                    interpolate(pick_coord(pic_w), pick_coord(pic_h),
                                $urandom_range(3), $urandom_range(3));
            end
            drain();
        end

        if (error_count == 0 && samples_pending == 0)
            $display("luma_quarter_pel_interpolation_core_test: clean");
        else
            $display("luma_quarter_pel_interpolation_core_test: errors");
        $finish;
    end

endmodule
